@@ sv/sssp_pkg.sv @@
// Package with shared constants for the shortest path block.
`default_nettype none
package sssp_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS = 22;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
endpackage
`default_nettype wire

@@ sv/sssp_req_if.sv @@
// Request channel carrying one input item.
`default_nettype none
interface sssp_req_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
    logic [15:0] edge_weight;
    logic [5:0] source_vertex;
    modport source (output valid, kind, edge_from, edge_to, edge_weight, source_vertex,
        input ready);
    modport sink (input valid, kind, edge_from, edge_to, edge_weight, source_vertex,
        output ready);
endinterface
`default_nettype wire

@@ sv/sssp_rsp_if.sv @@
// Result channel carrying one per-vertex result.
`default_nettype none
interface sssp_rsp_if;
    logic valid;
    logic ready;
    logic [5:0] vertex;
    logic [21:0] distance;
    logic reached;
    logic edges_dropped;
    logic last;
    modport source (output valid, vertex, distance, reached, edges_dropped, last,
        input ready);
    modport sink (input valid, vertex, distance, reached, edges_dropped, last,
        output ready);
endinterface
`default_nettype wire

@@ sv/sssp_cfg_if.sv @@
// Configuration write channel for the vertex count register.
`default_nettype none
interface sssp_cfg_if;
    logic valid;
    logic ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ sv/single_source_shortest_paths.sv @@
// Top level of the single source shortest path engine.
// Add and clear requests are handled in the idle state. A run request holds the
// request channel until the last of its n results is loaded into the output
// register, with n vertices in use. Each round scans the distance memory for the
// nearest unvisited vertex, one vertex per cycle, settles the choice in S_LAST and
// S_PICK, then walks the edge memory one edge at a time (edge read, distance
// read, compare and write back). Results leave through that output register, one
// per vertex in ascending order.
`default_nettype none
module single_source_shortest_paths #(
    parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES,
    parameter int MAX_EDGES = sssp_pkg::MAX_EDGES,
    parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    sssp_cfg_if.sink cfg,
    sssp_req_if.sink req,
    sssp_rsp_if.source rsp
);
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DB = sssp_pkg::DIST_BITS;
    localparam int SB = (DB > WEIGHT_BITS ? DB : WEIGHT_BITS) + 1;
    localparam int EW = 12 + WEIGHT_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_LAST = 9'b000000100,
        S_PICK = 9'b000001000,
        S_EDGE = 9'b000010000,
        S_EREAD = 9'b000100000,
        S_RELAX = 9'b001000000,
        S_OUT = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] vcount_reg;
    logic [EB:0] edge_total_reg;
    logic overflow_reg;
    logic [MAX_VERTICES-1:0] reached_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [6:0] n_reg;
    logic [6:0] idx_reg;
    logic [6:0] round_reg;
    logic [VB-1:0] pick_reg;
    logic pick_ok_reg;
    logic [DB-1:0] pick_dist_reg;
    logic [EB:0] eidx_reg;
    logic scan_vld_reg;
    logic [VB-1:0] scan_v_reg;

    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [EW-1:0] edge_rd_reg;
    logic [DB-1:0] dist_mem [MAX_VERTICES];
    logic [DB-1:0] dist_rd_reg;

    logic rsp_valid_reg;
    logic [5:0] rsp_vertex_reg;
    logic [DB-1:0] rsp_dist_reg;
    logic rsp_reached_reg;
    logic rsp_dropped_reg;
    logic rsp_last_reg;

    logic [6:0] n_eff;
    logic req_acc;
    logic run_acc;
    logic src_ok;
    logic [MAX_VERTICES-1:0] src_mask;
    logic [5:0] e_tail;
    logic [5:0] e_head;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [VB-1:0] head_v;
    logic head_ok;
    logic [SB-1:0] sum;
    logic [DB-1:0] cand;
    logic relax_hit;
    logic scan_take;
    logic edges_done;
    logic rsp_load;
    logic dist_we;
    logic [VB-1:0] dist_wa;
    logic [DB-1:0] dist_wd;
    logic [VB-1:0] dist_ra;
    logic [VB-1:0] idx_v;

    assign n_eff = (vcount_reg == 7'd0) ? 7'd1 :
        (vcount_reg > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_reg;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc = req.valid && req.ready;
    assign run_acc = req_acc && (req.kind == sssp_pkg::KIND_RUN);
    assign src_ok = ({1'b0, req.source_vertex} < n_eff);

    always_comb
    begin
        src_mask = '0;
        src_mask[VB'(req.source_vertex)] = src_ok;
    end

    assign {e_tail, e_head, e_w} = edge_rd_reg;
    assign head_v = VB'(e_head);
    assign head_ok = ({1'b0, e_head} < n_reg);
    assign sum = SB'(pick_dist_reg) + SB'(e_w);
    assign cand = (sum > SB'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX : sum[DB-1:0];
    assign relax_hit = (state_reg == S_RELAX) && (e_tail == 6'(pick_reg)) && head_ok
        && (!reached_reg[head_v] || dist_rd_reg > cand);
    assign edges_done = ((eidx_reg + 1'b1) >= edge_total_reg);

    assign idx_v = idx_reg[VB-1:0];

    // Reached vertices beat unreached ones; ties keep the lower vertex.
    assign scan_take = scan_vld_reg && !visited_reg[scan_v_reg]
        && (!pick_ok_reg || (reached_reg[scan_v_reg]
            && (!reached_reg[pick_reg] || dist_rd_reg < pick_dist_reg)));

    assign rsp_load = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 7'd64;
        end
        else if (cfg.valid && cfg.ready)
        begin
            vcount_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc && req.kind == sssp_pkg::KIND_ADD
            && edge_total_reg < (EB+1)'(MAX_EDGES))
        begin
            edge_mem[edge_total_reg[EB-1:0]] <= {req.edge_from, req.edge_to,
                WEIGHT_BITS'(req.edge_weight)};
        end
        edge_rd_reg <= edge_mem[eidx_reg[EB-1:0]];
    end

    // The source gets distance zero when a run starts; relaxation writes the rest.
    always_comb
    begin
        dist_we = 1'b0;
        dist_wa = head_v;
        dist_wd = cand;
        if (run_acc && src_ok)
        begin
            dist_we = 1'b1;
            dist_wa = VB'(req.source_vertex);
            dist_wd = '0;
        end
        else if (relax_hit)
        begin
            dist_we = 1'b1;
        end
        dist_ra = idx_v;
        if (state_reg == S_EREAD)
        begin
            dist_ra = head_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_rd_reg <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            edge_total_reg <= '0;
            overflow_reg <= 1'b0;
            reached_reg <= '0;
            visited_reg <= '0;
            n_reg <= '0;
            idx_reg <= '0;
            round_reg <= '0;
            pick_reg <= '0;
            pick_ok_reg <= 1'b0;
            pick_dist_reg <= '0;
            eidx_reg <= '0;
            scan_vld_reg <= 1'b0;
            scan_v_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_vertex_reg <= '0;
            rsp_dist_reg <= '0;
            rsp_reached_reg <= 1'b0;
            rsp_dropped_reg <= 1'b0;
            rsp_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_load ? 1'b1 : (rsp_valid_reg && !rsp.ready);
            scan_vld_reg <= (state_reg == S_SCAN);
            scan_v_reg <= idx_v;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        case (req.kind)
                            sssp_pkg::KIND_ADD:
                            begin
                                if (edge_total_reg < (EB+1)'(MAX_EDGES))
                                begin
                                    edge_total_reg <= edge_total_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            sssp_pkg::KIND_CLEAR:
                            begin
                                edge_total_reg <= '0;
                                overflow_reg <= 1'b0;
                            end
                            sssp_pkg::KIND_RUN:
                            begin
                                n_reg <= n_eff;
                                visited_reg <= '0;
                                reached_reg <= src_mask;
                                round_reg <= '0;
                                idx_reg <= '0;
                                pick_ok_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN, S_LAST:
                begin
                    idx_reg <= idx_reg + 7'd1;
                    if (scan_take)
                    begin
                        pick_reg <= scan_v_reg;
                        pick_ok_reg <= 1'b1;
                        pick_dist_reg <= dist_rd_reg;
                    end
                end
                S_PICK:
                begin
                    pick_ok_reg <= 1'b0;
                    idx_reg <= '0;
                    eidx_reg <= '0;
                    if (pick_ok_reg)
                    begin
                        visited_reg[pick_reg] <= 1'b1;
                        round_reg <= round_reg + 7'd1;
                    end
                end
                S_RELAX:
                begin
                    eidx_reg <= eidx_reg + 1'b1;
                    idx_reg <= '0;
                    if (relax_hit)
                    begin
                        reached_reg[head_v] <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (rsp_load)
                    begin
                        idx_reg <= idx_reg + 7'd1;
                        rsp_vertex_reg <= 6'(idx_reg);
                        rsp_reached_reg <= reached_reg[idx_v];
                        rsp_dist_reg <= reached_reg[idx_v] ? dist_rd_reg : '0;
                        rsp_dropped_reg <= overflow_reg;
                        rsp_last_reg <= (idx_reg + 7'd1 == n_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (run_acc)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg + 7'd1 >= n_reg)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!pick_ok_reg)
                begin
                    state_next = S_OUT;
                end
                else if (reached_reg[pick_reg] && edge_total_reg != '0)
                begin
                    state_next = S_EDGE;
                end
                else if (round_reg + 7'd1 >= n_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_EDGE:
            begin
                state_next = S_EREAD;
            end
            S_EREAD:
            begin
                state_next = S_RELAX;
            end
            S_RELAX:
            begin
                if (edges_done)
                begin
                    state_next = (round_reg >= n_reg) ? S_OUT : S_SCAN;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_OUT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (rsp_load)
                begin
                    state_next = (idx_reg + 7'd1 >= n_reg) ? S_IDLE : S_OUT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.vertex = rsp_vertex_reg;
    assign rsp.distance = rsp_dist_reg;
    assign rsp.reached = rsp_reached_reg;
    assign rsp.edges_dropped = rsp_dropped_reg;
    assign rsp.last = rsp_last_reg;

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= (EB+1)'(MAX_EDGES))
        else $error("edge total beyond capacity");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.vertex)
            && $stable(rsp.distance))
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
